@@ rtl/pcee_pkg.sv @@
// Shared types and constants for the prefix-compressed entry encoder.
// Used by pcee_front, pcee_queue, pcee_back and the top level; no dependencies.
`timescale 1ns / 1ps

package pcee_pkg;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_KEY     = 2'd1,
    REQ_KEY_END = 2'd2,
    REQ_VALUE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_KEY_TRUNC = 2'd1,
    ERR_SURPLUS   = 2'd2
  } err_t;

  // Six bits hold key lengths of up to 63 bytes
  localparam int KEY_LEN_W = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic {
    CMD_VALUE  = 1'b0,
    CMD_HEADER = 1'b1
  } cmd_kind_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             data;
    logic                   entry_end;
    err_t                   err;
    logic [KEY_LEN_W-1:0]   shared_len;
    logic [KEY_LEN_W-1:0]   key_len;
    logic [31:0]            value_total;
  } cmd_t;

endpackage

@@ rtl/pcee_queue.sv @@
// Small command queue between the front and back parts of the encoder.
// Depends on pcee_pkg for the command type and depth.
`timescale 1ns / 1ps

module pcee_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcee_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output pcee_pkg::cmd_t rdata,
  output logic           empty
);
  import pcee_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/pcee_front.sv @@
// Front part: accepts requests, tracks the shared prefix against the stored key
// and queues header and value commands. Holds the key store. Depends on pcee_pkg.
`timescale 1ns / 1ps

module pcee_front #(
  parameter int MAX_KEY = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [1:0]                     in_tuser,   // req_type
  input  logic [39:0]                    in_tdata,   // data_byte, val_len
  input  logic                           q_full,
  output logic                           q_push,
  output pcee_pkg::cmd_t                 q_wdata,
  input  logic                           hdr_done,
  input  logic [pcee_pkg::KEY_LEN_W-1:0] key_rd_addr,
  output logic [7:0]                     key_rd_data
);
  import pcee_pkg::*;

  localparam int IW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int LW = $clog2(MAX_KEY + 1);

  logic [7:0]         key_mem [MAX_KEY];
  logic [MAX_KEY-1:0] key_vld_r;

  logic [LW-1:0] prev_key_len_r, prev_key_len_nxt;
  logic [LW-1:0] new_key_len_r,  new_key_len_nxt;
  logic [LW-1:0] shared_r,       shared_nxt;
  logic          matching_r,     matching_nxt;
  logic [31:0]   value_total_r,  value_total_nxt;
  logic [31:0]   value_count_r,  value_count_nxt;
  logic          trunc_r,        trunc_nxt;
  logic          hdr_pend_r,     hdr_pend_nxt;

  logic [7:0]    cmp_data_r;
  logic          cmp_vld_r;
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic [7:0]    cmp_byte;

  req_type_t     req;
  logic [7:0]    data_byte;
  logic [31:0]   val_len;
  logic          accept;
  logic          key_wr;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] cmp_idx;
  logic [IW-1:0] rd_idx;
  logic [31:0]   value_count_inc;

  assign req          = req_type_t'(in_tuser);
  assign data_byte    = in_tdata[7:0];
  assign val_len      = in_tdata[39:8];
  assign in_tready    = !hdr_pend_r && !q_full;
  assign accept       = in_tvalid && in_tready;

  assign cmp_byte    = cmp_vld_r ? cmp_data_r : 8'd0;
  assign key_rd_data = rd_vld_r ? rd_data_r : 8'd0;
  assign value_count_inc = value_count_r + 32'd1;

  always_comb begin
    prev_key_len_nxt = prev_key_len_r;
    new_key_len_nxt  = new_key_len_r;
    shared_nxt       = shared_r;
    matching_nxt     = matching_r;
    value_total_nxt  = value_total_r;
    value_count_nxt  = value_count_r;
    trunc_nxt        = trunc_r;
    hdr_pend_nxt     = hdr_pend_r && !hdr_done;
    key_wr           = 1'b0;
    q_push           = 1'b0;
    q_wdata          = '0;
    q_wdata.kind     = CMD_VALUE;
    q_wdata.err      = ERR_NONE;
    if (accept) begin
      unique case (req)
        REQ_BEGIN: begin
          value_total_nxt = val_len;
          value_count_nxt = '0;
          new_key_len_nxt = '0;
          shared_nxt      = '0;
          matching_nxt    = 1'b1;
          trunc_nxt       = 1'b0;
        end
        REQ_KEY: begin
          if (new_key_len_r >= LW'(MAX_KEY)) begin
            trunc_nxt = 1'b1;
          end else begin
            if (matching_r && (new_key_len_r < prev_key_len_r) && (cmp_byte == data_byte)) begin
              shared_nxt = shared_r + LW'(1);
            end else begin
              matching_nxt = 1'b0;
            end
            key_wr          = 1'b1;
            new_key_len_nxt = new_key_len_r + LW'(1);
          end
        end
        REQ_KEY_END: begin
          q_push              = 1'b1;
          q_wdata.kind        = CMD_HEADER;
          q_wdata.shared_len  = KEY_LEN_W'(shared_r);
          q_wdata.key_len     = KEY_LEN_W'(new_key_len_r);
          q_wdata.value_total = value_total_r;
          q_wdata.err         = trunc_r ? ERR_KEY_TRUNC : ERR_NONE;
          prev_key_len_nxt    = new_key_len_r;
          // key store must stay put until the back has read the key bytes out
          hdr_pend_nxt        = 1'b1;
        end
        REQ_VALUE: begin
          q_push = 1'b1;
          if (value_count_r >= value_total_r) begin
            q_wdata.err = ERR_SURPLUS;
          end else begin
            value_count_nxt   = value_count_inc;
            q_wdata.data      = data_byte;
            q_wdata.entry_end = (value_count_inc == value_total_r);
          end
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  assign wr_idx  = new_key_len_r[IW-1:0];
  // compare port always looks one write ahead, so its data lines up with new_key_len_r
  assign cmp_idx = (new_key_len_nxt < LW'(MAX_KEY)) ? new_key_len_nxt[IW-1:0] : '0;
  assign rd_idx  = (key_rd_addr < KEY_LEN_W'(MAX_KEY)) ? key_rd_addr[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[wr_idx] <= data_byte;
    end
    cmp_data_r <= key_mem[cmp_idx];
    rd_data_r  <= key_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r      <= '0;
      cmp_vld_r      <= 1'b0;
      rd_vld_r       <= 1'b0;
      prev_key_len_r <= '0;
      new_key_len_r  <= '0;
      shared_r       <= '0;
      matching_r     <= 1'b1;
      value_total_r  <= '0;
      value_count_r  <= '0;
      trunc_r        <= 1'b0;
      hdr_pend_r     <= 1'b0;
    end else begin
      if (key_wr) begin
        key_vld_r[wr_idx] <= 1'b1;
      end
      cmp_vld_r      <= key_vld_r[cmp_idx];
      rd_vld_r       <= key_vld_r[rd_idx];
      prev_key_len_r <= prev_key_len_nxt;
      new_key_len_r  <= new_key_len_nxt;
      shared_r       <= shared_nxt;
      matching_r     <= matching_nxt;
      value_total_r  <= value_total_nxt;
      value_count_r  <= value_count_nxt;
      trunc_r        <= trunc_nxt;
      hdr_pend_r     <= hdr_pend_nxt;
    end
  end

endmodule

@@ rtl/pcee_back.sv @@
// Back part: drains commands, emits the varint header and unshared key bytes,
// passes value bytes and holds the output register. Depends on pcee_pkg.
`timescale 1ns / 1ps

module pcee_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  pcee_pkg::cmd_t                 q_head,
  output logic                           q_pop,
  output logic                           hdr_done,
  output logic [pcee_pkg::KEY_LEN_W-1:0] key_rd_addr,
  input  logic [7:0]                     key_rd_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // out_byte
  output logic                           out_tlast,  // run_last
  output logic [2:0]                     out_tuser   // entry_end, error[1:0]
);
  import pcee_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SHARED   = 5'b00010,
    ST_UNSHARED = 5'b00100,
    ST_VLEN     = 5'b01000,
    ST_KEY      = 5'b10000
  } back_state_t;

  back_state_t          state_r,   state_nxt;
  cmd_t                 hdr_r,     hdr_nxt;
  logic [31:0]          vl_r,      vl_nxt;
  logic [KEY_LEN_W-1:0] key_idx_r, key_idx_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_end_r;
  err_t       out_err_r;

  logic       ld_ok;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       emit_end;
  err_t       emit_err;
  logic       vl_more;
  logic [KEY_LEN_W-1:0] key_idx_inc;

  assign ld_ok       = !out_valid_r || out_tready;
  assign vl_more     = |vl_r[31:7];
  assign key_idx_inc = key_idx_r + KEY_LEN_W'(1);
  // read one ahead: the registered key data always matches key_idx_r
  assign key_rd_addr = key_idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    hdr_nxt     = hdr_r;
    vl_nxt      = vl_r;
    key_idx_nxt = key_idx_r;
    q_pop       = 1'b0;
    hdr_done    = 1'b0;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_last   = 1'b0;
    emit_end    = 1'b0;
    emit_err    = hdr_r.err;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == CMD_HEADER) begin
            q_pop       = 1'b1;
            hdr_nxt     = q_head;
            vl_nxt      = q_head.value_total;
            key_idx_nxt = q_head.shared_len;
            state_nxt   = ST_SHARED;
          end else if (ld_ok) begin
            q_pop     = 1'b1;
            emit      = 1'b1;
            emit_byte = q_head.data;
            emit_last = 1'b1;
            emit_end  = q_head.entry_end;
            emit_err  = q_head.err;
          end
        end
      end
      ST_SHARED: begin
        if (ld_ok) begin
          emit      = 1'b1;
          emit_byte = 8'(hdr_r.shared_len);
          state_nxt = ST_UNSHARED;
        end
      end
      ST_UNSHARED: begin
        if (ld_ok) begin
          emit      = 1'b1;
          emit_byte = 8'(hdr_r.key_len - hdr_r.shared_len);
          state_nxt = ST_VLEN;
        end
      end
      ST_VLEN: begin
        if (ld_ok) begin
          emit      = 1'b1;
          emit_byte = {vl_more, vl_r[6:0]};
          if (vl_more) begin
            vl_nxt = {7'd0, vl_r[31:7]};
          end else if (hdr_r.key_len == hdr_r.shared_len) begin
            emit_last = 1'b1;
            emit_end  = (hdr_r.value_total == 32'd0);
            hdr_done  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        if (ld_ok) begin
          emit        = 1'b1;
          emit_byte   = key_rd_data;
          key_idx_nxt = key_idx_inc;
          if (key_idx_inc == hdr_r.key_len) begin
            emit_last = 1'b1;
            emit_end  = (hdr_r.value_total == 32'd0);
            hdr_done  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      key_idx_r <= key_idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    vl_r  <= vl_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_end_r  <= emit_end;
      out_err_r  <= emit_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_end_r};

endmodule

@@ rtl/prefix_compressed_entry_encoder.sv @@
// Top level of the prefix-compressed key/value entry encoder.
// Ties pcee_front, pcee_queue and pcee_back together; depends on pcee_pkg.
//
// Usage:
//   Input stream (in_*): one request per transfer. in_tuser gives the kind
//   (begin entry, key byte, end of key, value byte); in_tdata carries the byte
//   and, on begin entry, the value length.
//   Output stream (out_*): one encoded byte per transfer. out_tlast marks the
//   last byte caused by one request, out_tuser the entry end and error code.
//   Begin, key and value requests are taken one per cycle while the command
//   queue has room and no header is in progress. An end-of-key request holds
//   the input until its last header byte is loaded: shared and unshared
//   lengths (one byte each), the value length as a 1 to 5 byte varint and
//   the unshared key bytes, one byte per cycle from the output register while
//   the receiver takes them. The header command passes through the queue, is
//   fetched by the idle sequencer, and then its bytes are loaded in that order.
//   A value byte passes through the command queue and the output register.
//   Reset clears all control state and the key store (via per-entry valid
//   bits). When the receiver stalls, the output register holds, the queue
//   fills and in_tready drops; nothing is lost.
`timescale 1ns / 1ps

module prefix_compressed_entry_encoder #(
  parameter int MAX_KEY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [39:0] in_tdata,   // data_byte[7:0], val_len[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // run_last
  output logic [2:0]  out_tuser   // entry_end[0], error[2:1]
);
  import pcee_pkg::*;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  cmd_t                 q_wdata;
  cmd_t                 q_rdata;
  logic                 hdr_done;
  logic [KEY_LEN_W-1:0] key_rd_addr;
  logic [7:0]           key_rd_data;

  pcee_front #(
    .MAX_KEY (MAX_KEY)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .hdr_done    (hdr_done),
    .key_rd_addr (key_rd_addr),
    .key_rd_data (key_rd_data)
  );

  pcee_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pcee_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_rdata),
    .q_pop       (q_pop),
    .hdr_done    (hdr_done),
    .key_rd_addr (key_rd_addr),
    .key_rd_data (key_rd_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
